// ----- sv/midi_byte_stream_parser_assert.svh -----
// Assertion macros for the MIDI byte stream parser.
`ifndef MIDI_BYTE_STREAM_PARSER_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MBSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbsp assertion failed");

// Next-cycle implication.
`define MBSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbsp assertion failed");

`endif

// ----- sv/mbsp_pkg.sv -----
// Package: byte classes, queue entry type and MIDI constants.
`timescale 1ns / 1ps
`default_nettype none
package mbsp_pkg;

   localparam int unsigned KIND_W = 3;

   localparam logic [KIND_W-1:0] CLS_DATA   = 3'd0;
   localparam logic [KIND_W-1:0] CLS_CHAN   = 3'd1;
   localparam logic [KIND_W-1:0] CLS_RT     = 3'd2;
   localparam logic [KIND_W-1:0] CLS_SYSEX  = 3'd3;
   localparam logic [KIND_W-1:0] CLS_COMMON = 3'd4;
   localparam logic [KIND_W-1:0] CLS_TUNE   = 3'd5;
   localparam logic [KIND_W-1:0] CLS_CLEAR  = 3'd6;

   localparam logic [7:0] ST_SYS_FIRST = 8'hF0;
   localparam logic [7:0] ST_RT_FIRST  = 8'hF8;
   localparam logic [7:0] ST_SYSEX     = 8'hF0;
   localparam logic [7:0] ST_QFRAME    = 8'hF1;
   localparam logic [7:0] ST_SONG_POS  = 8'hF2;
   localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
   localparam logic [7:0] ST_UNDEF_LO  = 8'hF4;
   localparam logic [7:0] ST_NONE      = 8'h00;

   localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
   localparam logic [3:0] NIB_POLY_PRES = 4'hA;
   localparam logic [3:0] NIB_CTRL      = 4'hB;
   localparam logic [3:0] NIB_PROGRAM   = 4'hC;
   localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
   localparam logic [3:0] NIB_BEND      = 4'hE;

   localparam logic [2:0] SYS_SYSEX = 3'd0;
   localparam logic [2:0] SYS_QF    = 3'd1;
   localparam logic [2:0] SYS_SPP   = 3'd2;
   localparam logic [2:0] SYS_SSEL  = 3'd3;
   localparam logic [2:0] SYS_TUNE  = 3'd6;

   localparam logic [6:0] CTRL_MODE_FIRST = 7'd120;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data;
   } item_type;

endpackage
`default_nettype wire

// ----- sv/mbsp_front.sv -----
// Front end: classifies each received byte into a queue entry.
`timescale 1ns / 1ps
`default_nettype none
module mbsp_front (
   input  wire logic [7:0]       rx_byte,
   output mbsp_pkg::item_type    item
);
   import mbsp_pkg::*;

   logic [KIND_W-1:0] kind;

   always_comb begin
      if (!rx_byte[7]) begin
         kind = CLS_DATA;
      end else if (rx_byte < ST_SYS_FIRST) begin
         kind = CLS_CHAN;
      end else if (rx_byte >= ST_RT_FIRST) begin
         kind = CLS_RT;
      end else begin
         case (rx_byte[2:0])
            SYS_SYSEX: kind = CLS_SYSEX;
            SYS_QF, SYS_SPP, SYS_SSEL: kind = CLS_COMMON;
            SYS_TUNE: kind = CLS_TUNE;
            default: kind = CLS_CLEAR;
         endcase
      end
   end

   assign item.kind = kind;
   assign item.data = rx_byte;

endmodule
`default_nettype wire

// ----- sv/mbsp_queue.sv -----
// Short register queue between the front end and the message engine.
`timescale 1ns / 1ps
`default_nettype none
module mbsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mbsp_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output mbsp_pkg::item_type      head_item
);
   import mbsp_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- sv/mbsp_back.sv -----
// Message engine: running status state, message assembly and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "midi_byte_stream_parser_assert.svh"
module mbsp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire mbsp_pkg::item_type head_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_status_byte,
   output logic [3:0]              rsp_channel,
   output logic [6:0]              rsp_first_data,
   output logic [6:0]              rsp_second_data,
   output logic                    rsp_channel_mode
);
   import mbsp_pkg::*;

   logic [7:0] rs_ff, rs_in;
   logic       have_ff, have_in;
   logic [6:0] held_ff, held_in;

   logic       valid_ff, valid_in;
   logic [7:0] st_ff;
   logic [3:0] ch_ff;
   logic [6:0] d1_ff, d2_ff;
   logic       mode_ff;

   logic       emit;
   logic [7:0] e_st;
   logic [3:0] e_ch;
   logic [6:0] e_d1, e_d2;
   logic       e_mode;
   logic [6:0] b7;

   assign pop = head_valid && (!valid_ff || rsp_ready);
   assign b7  = head_item.data[6:0];

   always_comb begin
      rs_in   = rs_ff;
      have_in = have_ff;
      held_in = held_ff;
      emit    = 1'b0;
      e_st    = '0;
      e_ch    = '0;
      e_d1    = '0;
      e_d2    = '0;
      e_mode  = 1'b0;
      if (pop) begin
         case (head_item.kind)
            CLS_CHAN, CLS_COMMON: begin
               rs_in   = head_item.data;
               have_in = 1'b0;
            end
            CLS_SYSEX: begin
               rs_in = head_item.data;
            end
            CLS_RT: begin
               emit = 1'b1;
               e_st = head_item.data;
            end
            CLS_TUNE: begin
               rs_in = ST_NONE;
               emit  = 1'b1;
               e_st  = head_item.data;
            end
            CLS_CLEAR: begin
               rs_in = ST_NONE;
            end
            CLS_DATA: begin
               case (rs_ff[7:4])
                  NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRES, NIB_CTRL, NIB_BEND: begin
                     if (!have_ff) begin
                        held_in = b7;
                        have_in = 1'b1;
                     end else begin
                        have_in = 1'b0;
                        emit    = 1'b1;
                        e_ch    = rs_ff[3:0];
                        e_d1    = held_ff;
                        e_d2    = b7;
                        if (rs_ff[7:4] == NIB_NOTE_ON && b7 == '0) begin
                           e_st = {NIB_NOTE_OFF, rs_ff[3:0]};
                        end else begin
                           e_st = rs_ff;
                        end
                        if (rs_ff[7:4] == NIB_CTRL) begin
                           e_mode = (held_ff >= CTRL_MODE_FIRST);
                        end
                     end
                  end
                  NIB_PROGRAM, NIB_CHAN_PRES: begin
                     emit = 1'b1;
                     e_st = rs_ff;
                     e_ch = rs_ff[3:0];
                     e_d1 = b7;
                  end
                  default: begin
                     case (rs_ff)
                        ST_QFRAME: begin
                           rs_in = ST_NONE;
                           emit  = 1'b1;
                           e_st  = rs_ff;
                           e_d1  = {4'b0, b7[6:4]};
                           e_d2  = {3'b0, b7[3:0]};
                        end
                        ST_SONG_POS: begin
                           if (!have_ff) begin
                              held_in = b7;
                              have_in = 1'b1;
                           end else begin
                              have_in = 1'b0;
                              rs_in   = ST_NONE;
                              emit    = 1'b1;
                              e_st    = rs_ff;
                              e_d1    = held_ff;
                              e_d2    = b7;
                           end
                        end
                        ST_SONG_SEL: begin
                           rs_in = ST_NONE;
                           emit  = 1'b1;
                           e_st  = rs_ff;
                           e_d1  = b7;
                        end
                        ST_SYSEX: begin
                           rs_in = rs_ff;
                        end
                        default: begin
                           if (rs_ff >= ST_UNDEF_LO) begin
                              rs_in = ST_NONE;
                           end
                        end
                     endcase
                  end
               endcase
            end
            default: begin
               rs_in = rs_ff;
            end
         endcase
      end
   end

   assign valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff    <= ST_NONE;
         have_ff  <= 1'b0;
         held_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         rs_ff    <= rs_in;
         have_ff  <= have_in;
         held_ff  <= held_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         st_ff   <= e_st;
         ch_ff   <= e_ch;
         d1_ff   <= e_d1;
         d2_ff   <= e_d2;
         mode_ff <= e_mode;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status_byte  = st_ff;
   assign rsp_channel      = ch_ff;
   assign rsp_first_data   = d1_ff;
   assign rsp_second_data  = d2_ff;
   assign rsp_channel_mode = mode_ff;

   `MBSP_ASSERT_NOW(a_no_pop_on_stall, clock, reset, valid_ff && !rsp_ready, !pop)
   `MBSP_ASSERT_NOW(a_mode_only_ctrl, clock, reset, valid_ff && mode_ff, st_ff[7:4] == NIB_CTRL)
   `MBSP_ASSERT_NOW(a_stray_data_silent, clock, reset, pop && head_item.kind == CLS_DATA && rs_ff == ST_NONE, !emit)
   `MBSP_ASSERT_NEXT(a_rt_keeps_state, clock, reset, pop && head_item.kind == CLS_RT, $stable(rs_ff) && $stable(have_ff) && $stable(held_ff))

endmodule
`default_nettype wire

// ----- sv/midi_byte_stream_parser.sv -----
// Top level: MIDI byte stream parser with running status.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_rx_byte
//   rsp     | out       | rsp_valid, rsp_ready, rsp_status_byte, rsp_channel,
//           |           | rsp_first_data, rsp_second_data, rsp_channel_mode
//
// One byte per cycle sustained unless rsp_ready stalls; a byte passes the
// queue register, then the message engine, into the output register.
// The engine sets the rate: one byte per cycle, unless rsp_ready stalls it.
// req_ready drops only when the two-entry queue is full.
// Synchronous reset clears running status, the held data flag and all valids.
`timescale 1ns / 1ps
`default_nettype none
module midi_byte_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_status_byte,
   output logic [3:0]       rsp_channel,
   output logic [6:0]       rsp_first_data,
   output logic [6:0]       rsp_second_data,
   output logic             rsp_channel_mode
);
   import mbsp_pkg::*;

   item_type in_item;
   item_type head_item;
   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     head_valid;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   mbsp_front u_front (
      .rx_byte (req_rx_byte),
      .item    (in_item)
   );

   mbsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (in_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mbsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_channel      (rsp_channel),
      .rsp_first_data   (rsp_first_data),
      .rsp_second_data  (rsp_second_data),
      .rsp_channel_mode (rsp_channel_mode)
   );

endmodule
`default_nettype wire
